// ===== rtl/bffsc_pkg.sv =====
// Package for the bitmap find-first-set/clear block.
// Holds default sizes, the command codes and the search result type.
// No dependencies.
package bffsc_pkg;

  localparam int NUM_BITS_DEF  = 256;
  localparam int WORD_BITS_DEF = 64;
  localparam int CMD_W         = 3;
  localparam int INDEX_W       = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE      = 3'd0,
    CMD_SET_BIT   = 3'd1,
    CMD_CLEAR_BIT = 3'd2,
    CMD_SET_ALL   = 3'd3,
    CMD_CLEAR_ALL = 3'd4
  } cmd_t;

  // Answer of one priority search over the bitmap
  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] index;
  } find_t;

endpackage

// ===== rtl/bffsc_update.sv =====
// Next-state logic of the bitmap: applies one command and reads back the indexed bit.
// Depends on bffsc_pkg.
module bffsc_update #(
  parameter int NUM_BITS = bffsc_pkg::NUM_BITS_DEF
) (
  input  logic [NUM_BITS-1:0]          bitmap,
  input  logic [bffsc_pkg::CMD_W-1:0]  cmd,
  input  logic [bffsc_pkg::INDEX_W-1:0] bit_index,
  output logic [NUM_BITS-1:0]          bitmap_next,
  output logic                         bit_is_set
);

  logic [NUM_BITS-1:0] mask;

  // Decode the index; an index past the array shifts out to an empty mask
  assign mask = {{(NUM_BITS-1){1'b0}}, 1'b1} << bit_index;

  // Apply the command; unknown codes leave the bitmap alone
  always_comb begin
    unique case (cmd)
      bffsc_pkg::CMD_SET_BIT:   bitmap_next = bitmap | mask;
      bffsc_pkg::CMD_CLEAR_BIT: bitmap_next = bitmap & ~mask;
      bffsc_pkg::CMD_SET_ALL:   bitmap_next = {NUM_BITS{1'b1}};
      bffsc_pkg::CMD_CLEAR_ALL: bitmap_next = {NUM_BITS{1'b0}};
      default:                  bitmap_next = bitmap;
    endcase
  end

  // Read back the indexed bit after the update
  assign bit_is_set = |(bitmap_next & mask);

endmodule

// ===== rtl/bffsc_search.sv =====
// Two-level priority search: lowest set bit of a vector, word by word.
// Depends on bffsc_pkg.
module bffsc_search #(
  parameter int NUM_BITS  = bffsc_pkg::NUM_BITS_DEF,
  parameter int WORD_BITS = bffsc_pkg::WORD_BITS_DEF
) (
  input  logic [NUM_BITS-1:0] vec,
  output bffsc_pkg::find_t    result
);

  localparam int NUM_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int PAD_BITS  = NUM_WORDS * WORD_BITS;
  localparam int POS_W     = $clog2(WORD_BITS);
  localparam int FULL_W    = ($clog2(PAD_BITS) > bffsc_pkg::INDEX_W) ?
                             $clog2(PAD_BITS) : bffsc_pkg::INDEX_W;

  logic [PAD_BITS-1:0]  padded;
  logic [NUM_WORDS-1:0] word_any;
  logic [NUM_WORDS-1:0] word_first;
  logic [POS_W-1:0]     word_pos [NUM_WORDS];
  logic [FULL_W-1:0]    full_index;

  // Pad the tail of the last word with zeros so it never matches
  assign padded = PAD_BITS'(vec);

  // Find the lowest set bit inside each word by isolating it
  always_comb begin
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] iso;
    for (int w = 0; w < NUM_WORDS; w++) begin
      word        = padded[w*WORD_BITS +: WORD_BITS];
      iso         = word & (~word + {{(WORD_BITS-1){1'b0}}, 1'b1});
      word_any[w] = |word;
      word_pos[w] = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
        if (iso[b]) word_pos[w] = word_pos[w] | POS_W'(b);
      end
    end
  end

  // Pick the lowest non-empty word
  assign word_first = word_any & (~word_any + {{(NUM_WORDS-1){1'b0}}, 1'b1});

  // Combine word base and position of the selected word
  always_comb begin
    full_index = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (word_first[w]) begin
        full_index = full_index | (FULL_W'(w * WORD_BITS) + FULL_W'(word_pos[w]));
      end
    end
  end

  assign result.found = |word_any;
  assign result.index = full_index[bffsc_pkg::INDEX_W-1:0];

endmodule

// ===== rtl/bitmap_find_first_set_clear.sv =====
// Bitmap with set/clear commands and lowest-set / lowest-clear search.
// Depends on bffsc_pkg, bffsc_update and bffsc_search.
//
// Usage:
//   Input channel (in_valid/in_ready) carries cmd and bit_index. Output
//   channel (out_valid/out_ready) carries the bit state after the update,
//   the lowest set index with any_set, and the lowest clear index with
//   any_clear. One result transaction per input transaction, in order.
//   Path: an accepted input is loaded into the input register, then its
//   result is loaded into the result register when that stage can advance.
//   Throughput: one transaction per cycle while out_ready is high; the
//   bitmap update and both searches are combinational between the input
//   register and the result register, and the next command sees the
//   updated bitmap.
//   Reset: the bitmap clears to all zeros and both stages empty.
//   Stall: when out_ready is low the result holds; the input register
//   still takes one more transaction, after which in_ready drops until the
//   result is taken. No transaction is lost or repeated.
module bitmap_find_first_set_clear #(
  parameter int NUM_BITS  = bffsc_pkg::NUM_BITS_DEF,
  parameter int WORD_BITS = bffsc_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bffsc_pkg::CMD_W-1:0]   cmd,
  input  logic [bffsc_pkg::INDEX_W-1:0] bit_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          bit_is_set,
  output logic [bffsc_pkg::INDEX_W-1:0] first_set_index,
  output logic                          any_set,
  output logic [bffsc_pkg::INDEX_W-1:0] first_clear_index,
  output logic                          any_clear
);

  logic                          s1_valid;
  logic [bffsc_pkg::CMD_W-1:0]   s1_cmd;
  logic [bffsc_pkg::INDEX_W-1:0] s1_index;
  logic [NUM_BITS-1:0]           bitmap;
  logic [NUM_BITS-1:0]           bitmap_next;
  logic                          bit_next;
  bffsc_pkg::find_t              set_find;
  bffsc_pkg::find_t              clear_find;
  logic                          advance;
  logic                          s1_fire;

  // Pipeline control
  assign advance  = !out_valid || out_ready;
  assign s1_fire  = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  // Hold the input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd   <= cmd;
      s1_index <= bit_index;
    end
  end

  bffsc_update #(
    .NUM_BITS (NUM_BITS)
  ) u_update (
    .bitmap      (bitmap),
    .cmd         (s1_cmd),
    .bit_index   (s1_index),
    .bitmap_next (bitmap_next),
    .bit_is_set  (bit_next)
  );

  bffsc_search #(
    .NUM_BITS  (NUM_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_search_set (
    .vec    (bitmap_next),
    .result (set_find)
  );

  bffsc_search #(
    .NUM_BITS  (NUM_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_search_clear (
    .vec    (~bitmap_next),
    .result (clear_find)
  );

  // Commit the bitmap when the command moves to the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap <= '0;
    end else if (s1_fire) begin
      bitmap <= bitmap_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      bit_is_set        <= bit_next;
      first_set_index   <= set_find.index;
      any_set           <= set_find.found;
      first_clear_index <= clear_find.index;
      any_clear         <= clear_find.found;
    end
  end

endmodule

// ===== rtl/bffsc_checker.sv =====
// Port-level checker for the bitmap find-first-set/clear block, bound to the top level.
// Depends on bffsc_pkg and bitmap_find_first_set_clear.
module bffsc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          bit_is_set,
  input logic [bffsc_pkg::INDEX_W-1:0] first_set_index,
  input logic                          any_set,
  input logic [bffsc_pkg::INDEX_W-1:0] first_clear_index,
  input logic                          any_clear
);

  // Result stage is empty right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result transaction holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bit_is_set) &&
      $stable(first_set_index) && $stable(any_set) &&
      $stable(first_clear_index) && $stable(any_clear))
    else $error("stalled result changed");

  // The bitmap always holds a one or a zero somewhere
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> any_set || any_clear)
    else $error("bitmap reported neither set nor clear bits");

  // Empty search reports index zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !any_set |-> first_set_index == '0)
    else $error("first_set_index nonzero with no set bit");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !any_clear |-> first_clear_index == '0)
    else $error("first_clear_index nonzero with no clear bit");

endmodule

bind bitmap_find_first_set_clear bffsc_checker u_bffsc_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .bit_is_set        (bit_is_set),
  .first_set_index   (first_set_index),
  .any_set           (any_set),
  .first_clear_index (first_clear_index),
  .any_clear         (any_clear)
);
